### hdl/rpwr_pkg.sv
`default_nettype none

package rpwr_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdW        = 4;
  localparam int unsigned CntW       = 5;
  localparam int unsigned SeedW      = 32;
  localparam int unsigned DrawW      = 23;
  localparam int unsigned ProdW      = 36;

  localparam logic [CntW-1:0]  EntryCountRst = 5'd16;
  localparam logic [SeedW-1:0] SeedInitRst   = 32'd1;
  localparam logic [16:0]      LcgMult       = 17'd69069;
  localparam logic [3:0]       LastRound     = 4'd9;
  localparam logic [7:0]       LastSkip      = 8'd255;
  localparam logic [30:0]      HalfRem       = 31'h4000_0000;

  localparam logic [1:0] CmdNext   = 2'd0;
  localparam logic [1:0] CmdRandom = 2'd1;
  localparam logic [1:0] CmdErase  = 2'd2;

  localparam logic RegSeedInit   = 1'b0;
  localparam logic RegEntryCount = 1'b1;

  typedef struct packed {
    logic            load_master;
    logic [CntW-1:0] load_n;
    logic            refill;
    logic            pend_remove;
    logic [IdW-1:0]  pend_idx;
    logic            master_remove;
    logic [IdW-1:0]  master_idx;
  } list_ctrl_t;

  typedef struct packed {
    logic [CntW-1:0] pend_count;
    logic [CntW-1:0] master_count;
    logic [IdW-1:0]  pend_data;
    logic [IdW-1:0]  master_data;
  } list_stat_t;

endpackage

`default_nettype wire

### hdl/rpwr_mul.sv
`default_nettype none

module rpwr_mul (
  input  wire logic                       sel_scale_i,
  input  wire logic [rpwr_pkg::SeedW-1:0] seed_i,
  input  wire logic [rpwr_pkg::DrawW-1:0] draw_i,
  input  wire logic [rpwr_pkg::CntW-1:0]  count_i,
  output logic      [rpwr_pkg::SeedW-1:0] seed_o,
  output logic      [rpwr_pkg::ProdW-1:0] prod_o
);
  import rpwr_pkg::*;

  logic [31:0] op_a;
  logic [16:0] op_b;
  logic [48:0] prod;

  // One 32 x 17 multiplier serves both the generator step and the index scaling.
  assign op_a   = sel_scale_i ? {1'b0, draw_i, 8'b0} : seed_i;
  assign op_b   = sel_scale_i ? {12'b0, count_i} : LcgMult;
  assign prod   = {17'b0, op_a} * {32'b0, op_b};
  assign seed_o = prod[SeedW-1:0];
  assign prod_o = prod[ProdW-1:0];

endmodule

`default_nettype wire

### hdl/rpwr_lists.sv
`default_nettype none

module rpwr_lists (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rpwr_pkg::list_ctrl_t ctrl_i,
  output rpwr_pkg::list_stat_t      stat_o
);
  import rpwr_pkg::*;

  logic [IdW-1:0]  master_q [MaxEntries];
  logic [IdW-1:0]  pend_q [MaxEntries];
  logic [CntW-1:0] master_cnt_q;
  logic [CntW-1:0] pend_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MaxEntries; j++) begin
        master_q[j] <= (CntW'(j) < EntryCountRst) ? IdW'(j) : '0;
      end
      master_cnt_q <= EntryCountRst;
      pend_cnt_q   <= '0;
    end else if (ctrl_i.load_master) begin
      for (int j = 0; j < MaxEntries; j++) begin
        master_q[j] <= (CntW'(j) < ctrl_i.load_n) ? IdW'(j) : '0;
      end
      master_cnt_q <= ctrl_i.load_n;
      pend_cnt_q   <= '0;
    end else begin
      if (ctrl_i.master_remove) begin
        for (int j = 0; j < MaxEntries - 1; j++) begin
          if (IdW'(j) >= ctrl_i.master_idx) begin
            master_q[j] <= master_q[j+1];
          end
        end
        master_cnt_q <= master_cnt_q - CntW'(1);
      end
      if (ctrl_i.refill) begin
        pend_cnt_q <= master_cnt_q;
      end else if (ctrl_i.pend_remove) begin
        pend_cnt_q <= pend_cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.refill) begin
      for (int j = 0; j < MaxEntries; j++) begin
        pend_q[j] <= master_q[j];
      end
    end else if (ctrl_i.pend_remove) begin
      for (int j = 0; j < MaxEntries - 1; j++) begin
        if (IdW'(j) >= ctrl_i.pend_idx) begin
          pend_q[j] <= pend_q[j+1];
        end
      end
    end
  end

  assign stat_o.pend_count   = pend_cnt_q;
  assign stat_o.master_count = master_cnt_q;
  assign stat_o.pend_data    = pend_q[ctrl_i.pend_idx];
  assign stat_o.master_data  = master_q[ctrl_i.master_idx];

endmodule

`default_nettype wire

### hdl/random_pick_without_replacement.sv
// Next passes through refill, check and pick to the output register; erase searches the
// master list; random adds the draws, scale and round, with a generator step per skipped zero draw.
// One transaction at a time; the random pick is set by the shared 32 x 17 multiplier,
// which advances the generator by one step per cycle for ten draws.
// Reset (asynchronous, active low) clears control, loads ids 0 to 15 into the master
// list, empties the pending list and sets the seed to 1; no clearing pass is needed.
`default_nettype none

module random_pick_without_replacement (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [rpwr_pkg::IdW-1:0]  erase_id_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           valid_res_o,
  output logic      [rpwr_pkg::IdW-1:0]  entry_id_o,
  output logic      [rpwr_pkg::CntW-1:0] remaining_o
);
  import rpwr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REFILL,
    S_CHECK,
    S_DRAW,
    S_SCALE,
    S_ROUND,
    S_PICK,
    S_SEARCH,
    S_OUT
  } state_e;

  state_e          state_q;
  logic [1:0]      cmd_q;
  logic [IdW-1:0]  eid_q;
  logic [3:0]      round_q;
  logic [7:0]      skip_q;
  logic [DrawW-1:0] draw_q;
  logic [ProdW-1:0] prod_q;
  logic [IdW-1:0]  idx_q;
  logic [CntW-1:0] srch_q;
  logic            res_valid_q;
  logic [IdW-1:0]  res_id_q;
  logic [CntW-1:0] res_rem_q;
  logic            out_valid_q;
  logic            out_res_q;
  logic [IdW-1:0]  out_id_q;
  logic [CntW-1:0] out_rem_q;
  logic [SeedW-1:0] seed_q;
  logic [SeedW-1:0] seed_init_q;
  logic [CntW-1:0] entry_count_q;

  logic            cfg_wr;
  logic            seed_wr;
  logic            count_wr;
  logic [CntW-1:0] load_n;
  logic [SeedW-1:0] seed_nxt;
  logic [ProdW-1:0] prod;
  logic [DrawW-1:0] draw_nxt;
  logic [CntW-1:0] q_raw;
  logic [30:0]     rem;
  logic            rnd_up;
  logic [CntW-1:0] q_rnd;
  list_ctrl_t      ctrl;
  list_stat_t      stat;

  assign cfg_wr   = psel & penable & pwrite;
  assign seed_wr  = cfg_wr && (paddr[2] == RegSeedInit);
  assign count_wr = cfg_wr && (paddr[2] == RegEntryCount);
  assign load_n   = (pwdata[CntW-1:0] > CntW'(MaxEntries)) ? CntW'(MaxEntries)
                                                           : pwdata[CntW-1:0];
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == RegEntryCount) ? {27'b0, entry_count_q} : seed_init_q;

  rpwr_mul u_mul (
    .sel_scale_i (state_q == S_SCALE),
    .seed_i      (seed_q),
    .draw_i      (draw_q),
    .count_i     (stat.pend_count),
    .seed_o      (seed_nxt),
    .prod_o      (prod)
  );

  assign draw_nxt = seed_nxt[30:8];

  // Round half to even on the 31 bits dropped from draw times count.
  assign q_raw  = prod_q[ProdW-1:31];
  assign rem    = prod_q[30:0];
  assign rnd_up = (rem > HalfRem) || ((rem == HalfRem) && q_raw[0]);
  assign q_rnd  = q_raw + {{(CntW-1){1'b0}}, rnd_up};

  always_comb begin
    ctrl               = '0;
    ctrl.load_master   = count_wr;
    ctrl.load_n        = load_n;
    ctrl.refill        = (state_q == S_REFILL) && (stat.pend_count == '0);
    ctrl.pend_remove   = (state_q == S_PICK);
    ctrl.pend_idx      = idx_q;
    ctrl.master_idx    = srch_q[IdW-1:0];
    ctrl.master_remove = (state_q == S_SEARCH) && (srch_q < stat.master_count) &&
                         (stat.master_data == eid_q);
  end

  rpwr_lists u_lists (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_init_q   <= SeedInitRst;
      entry_count_q <= EntryCountRst;
      seed_q        <= SeedInitRst;
    end else begin
      if (seed_wr) begin
        seed_init_q <= pwdata;
        seed_q      <= pwdata;
      end else if (state_q == S_DRAW) begin
        seed_q <= seed_nxt;
      end
      if (count_wr) begin
        entry_count_q <= pwdata[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      eid_q       <= '0;
      round_q     <= '0;
      skip_q      <= '0;
      draw_q      <= '0;
      prod_q      <= '0;
      idx_q       <= '0;
      srch_q      <= '0;
      res_valid_q <= 1'b0;
      res_id_q    <= '0;
      res_rem_q   <= '0;
      out_res_q   <= 1'b0;
      out_id_q    <= '0;
      out_rem_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q  <= cmd_i;
            eid_q  <= erase_id_i;
            srch_q <= '0;
            if ((cmd_i == CmdNext) || (cmd_i == CmdRandom)) begin
              state_q <= S_REFILL;
            end else if (cmd_i == CmdErase) begin
              state_q <= S_SEARCH;
            end else begin
              res_valid_q <= 1'b0;
              res_id_q    <= '0;
              res_rem_q   <= stat.pend_count;
              state_q     <= S_OUT;
            end
          end
        end
        S_REFILL: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          round_q <= '0;
          skip_q  <= '0;
          if (stat.pend_count == '0) begin
            res_valid_q <= 1'b0;
            res_id_q    <= '0;
            res_rem_q   <= '0;
            state_q     <= S_OUT;
          end else if (cmd_q == CmdNext) begin
            idx_q   <= stat.pend_count[IdW-1:0] - IdW'(1);
            state_q <= S_PICK;
          end else begin
            state_q <= S_DRAW;
          end
        end
        S_DRAW: begin
          // A draw ends on a nonzero value or after 256 zero values in a row.
          if ((draw_nxt != '0) || (skip_q == LastSkip)) begin
            draw_q <= draw_nxt;
            skip_q <= '0;
            if (round_q == LastRound) begin
              state_q <= S_SCALE;
            end else begin
              round_q <= round_q + 4'd1;
            end
          end else begin
            skip_q <= skip_q + 8'd1;
          end
        end
        S_SCALE: begin
          prod_q  <= prod;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          idx_q   <= (q_rnd == stat.pend_count) ? '0 : q_rnd[IdW-1:0];
          state_q <= S_PICK;
        end
        S_PICK: begin
          res_valid_q <= 1'b1;
          res_id_q    <= stat.pend_data;
          res_rem_q   <= stat.pend_count - CntW'(1);
          state_q     <= S_OUT;
        end
        S_SEARCH: begin
          if (srch_q < stat.master_count) begin
            if (stat.master_data == eid_q) begin
              res_valid_q <= 1'b1;
              res_id_q    <= eid_q;
              res_rem_q   <= stat.pend_count;
              state_q     <= S_OUT;
            end else begin
              srch_q <= srch_q + CntW'(1);
            end
          end else begin
            res_valid_q <= 1'b0;
            res_id_q    <= '0;
            res_rem_q   <= stat.pend_count;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_res_q   <= res_valid_q;
            out_id_q    <= res_id_q;
            out_rem_q   <= res_rem_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign valid_res_o = out_res_q;
  assign entry_id_o  = out_id_q;
  assign remaining_o = out_rem_q;

`ifndef NO_ASSERTIONS
  // An entry is only removed from a pending list that holds at least one entry.
  a_pick_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> (stat.pend_count != '0))
    else $error("pick from an empty pending list");

  // The rounded index never exceeds the pending count before the wrap.
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (q_rnd <= stat.pend_count))
    else $error("rounded index out of range");

  // The seed moves only while drawing or on a register write.
  a_seed_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_DRAW) && !seed_wr) |=> (seed_q == $past(seed_q)))
    else $error("seed changed outside a draw");

  // A transaction without a valid result carries id zero.
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (entry_id_o == '0))
    else $error("nonzero id on an invalid result");
`endif

endmodule

`default_nettype wire
